[hw/rtl/crb_pkg.sv]
// ============================================================================
// crb_pkg: shared definitions for the clipped rectangle blit core
// Field widths, screen size limits, configuration register indexes and small
// helper functions for clamping sizes and forming the row stride.
// ============================================================================
package crb_pkg;

  // Field and register widths.
  localparam int PIXEL_W    = 24;
  localparam int OFFSET_W   = 27;
  localparam int SW_W       = 14;
  localparam int SH_W       = 13;
  localparam int COL_W      = 13;
  localparam int ROW_W      = 12;
  localparam int STRIDE_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Largest screen (and rectangle) size that the block addresses.
  localparam logic [SW_W-1:0] MAX_SCREEN_WIDTH  = 14'd8192;
  localparam logic [SH_W-1:0] MAX_SCREEN_HEIGHT = 13'd4096;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_DEST_COL      = 3'd2,
    REG_DEST_ROW      = 3'd3,
    REG_RECT_WIDTH    = 3'd4,
    REG_RECT_HEIGHT   = 3'd5
  } cfg_reg_t;

  // Limit a width to the largest screen width.
  function automatic logic [SW_W-1:0] cap_width(input logic [SW_W-1:0] v);
    return (v > MAX_SCREEN_WIDTH) ? MAX_SCREEN_WIDTH : v;
  endfunction

  // Limit a height to the largest screen height.
  function automatic logic [SH_W-1:0] cap_height(input logic [SH_W-1:0] v);
    return (v > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT : v;
  endfunction

  // Rectangle width: zero acts as one, then limited.
  function automatic logic [SW_W-1:0] clamp_width(input logic [SW_W-1:0] v);
    return (v == '0) ? SW_W'(1) : cap_width(v);
  endfunction

  // Rectangle height: zero acts as one, then limited.
  function automatic logic [SH_W-1:0] clamp_height(input logic [SH_W-1:0] v);
    return (v == '0) ? SH_W'(1) : cap_height(v);
  endfunction

  // Row stride in bytes: three bytes per pixel, formed as a shift and an add.
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [SW_W-1:0] w);
    return {w, 1'b0} + {1'b0, w};
  endfunction

endpackage

[hw/rtl/clipped_rectangle_blit_core.sv]
// ============================================================================
// clipped_rectangle_blit_core: place an RGB24 rectangle into a framebuffer
// Turns a row-ordered stream of source pixels into framebuffer writes with a
// byte offset, a write enable that clips off-screen pixels, and a last mark.
// ============================================================================
// Usage:
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
//   screen size, destination origin and rectangle size. It is always ready
//   and must only be written while no word is in flight. Indexes past the
//   register list are accepted and ignored.
//   Source pixels enter on in_valid/in_ready in row order; each accepted word
//   yields exactly one result word on out_valid/out_ready in the next cycle.
//   Throughput is one word per cycle unless stalled: the whole per-pixel
//   computation is one add/compare stage between the input and the result
//   register. The origin base (stride times destination row) is multiplied
//   at configuration time. When the receiver stalls, the result register
//   holds its word and in_ready stays high only if that word is taken in
//   the same cycle. Synchronous reset restores the register defaults (1x1
//   screen and rectangle at the origin), clears the column, row and row-base
//   counters and empties the result register.
// ============================================================================
module clipped_rectangle_blit_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [crb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [crb_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Source pixel channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [crb_pkg::PIXEL_W-1:0]           pixel_in,
  // Framebuffer write channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  write_enable,
  output logic [crb_pkg::OFFSET_W-1:0]          byte_offset,
  output logic [crb_pkg::PIXEL_W-1:0]           pixel_out,
  output logic                                  last
);
  import crb_pkg::*;

  // Configuration registers; sizes are stored already clamped.
  logic [SW_W-1:0]     scr_w;
  logic [SH_W-1:0]     scr_h;
  logic [COL_W-1:0]    dest_col;
  logic [ROW_W-1:0]    dest_row;
  logic [SW_W-1:0]     rect_w;
  logic [SH_W-1:0]     rect_h;
  logic [STRIDE_W-1:0] stride;
  logic [OFFSET_W-1:0] origin_base;

  // Position counters.
  logic [COL_W-1:0]    col_count;
  logic [ROW_W-1:0]    row_count;
  logic [OFFSET_W-1:0] row_base;

  logic cfg_fire;
  logic in_fire;

  // Configuration write datapath signals.
  logic [SW_W-1:0]     scr_w_wr;
  logic [STRIDE_W-1:0] stride_wr;
  logic [STRIDE_W-1:0] mul_a;
  logic [ROW_W-1:0]    mul_b;
  logic [OFFSET_W-1:0] origin_base_next;

  // Per-pixel datapath signals.
  logic [SW_W-1:0]     col_sum;
  logic [SH_W-1:0]     row_sum;
  logic [SW_W-1:0]     col_inc;
  logic [SH_W-1:0]     row_inc;
  logic [15:0]         col_bytes;
  logic [OFFSET_W-1:0] offset_sum;
  logic                origin_ok;
  logic                we_next;
  logic                row_end;
  logic                last_next;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // One shared multiplier forms the origin base from stride and destination
  // row, taking the new value of whichever of the two is being written.
  always_comb begin
    scr_w_wr  = cap_width(cfg_data[SW_W-1:0]);
    stride_wr = stride_of(scr_w_wr);
    mul_a     = (cfg_reg_t'(cfg_index) == REG_SCREEN_WIDTH) ? stride_wr : stride;
    mul_b     = (cfg_reg_t'(cfg_index) == REG_DEST_ROW) ? cfg_data[ROW_W-1:0] : dest_row;
    origin_base_next = OFFSET_W'(mul_a) * OFFSET_W'(mul_b);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w       <= SW_W'(1);
      scr_h       <= SH_W'(1);
      dest_col    <= '0;
      dest_row    <= '0;
      rect_w      <= SW_W'(1);
      rect_h      <= SH_W'(1);
      stride      <= stride_of(SW_W'(1));
      origin_base <= '0;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH: begin
          scr_w       <= scr_w_wr;
          stride      <= stride_wr;
          origin_base <= origin_base_next;
        end
        REG_SCREEN_HEIGHT: scr_h <= cap_height(cfg_data[SH_W-1:0]);
        REG_DEST_COL:      dest_col <= cfg_data[COL_W-1:0];
        REG_DEST_ROW: begin
          dest_row    <= cfg_data[ROW_W-1:0];
          origin_base <= origin_base_next;
        end
        REG_RECT_WIDTH:    rect_w <= clamp_width(cfg_data[SW_W-1:0]);
        REG_RECT_HEIGHT:   rect_h <= clamp_height(cfg_data[SH_W-1:0]);
        default: ;
      endcase
    end
  end

  // Clipping, end-of-row detection and byte offset for the incoming pixel.
  always_comb begin
    col_sum   = {1'b0, dest_col} + {1'b0, col_count};
    row_sum   = {1'b0, dest_row} + {1'b0, row_count};
    origin_ok = ({1'b0, dest_col} < scr_w) && ({1'b0, dest_row} < scr_h);
    we_next   = origin_ok && (col_sum < scr_w) && (row_sum < scr_h);
    col_inc   = {1'b0, col_count} + SW_W'(1);
    row_inc   = {1'b0, row_count} + SH_W'(1);
    row_end   = col_inc >= rect_w;
    last_next = row_end && (row_inc >= rect_h);
    col_bytes = {1'b0, col_sum, 1'b0} + {2'b00, col_sum};
    offset_sum = origin_base + row_base + OFFSET_W'(col_bytes);
  end

  // Position counters advance on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      row_base  <= '0;
    end else if (in_fire) begin
      if (last_next) begin
        col_count <= '0;
        row_count <= '0;
        row_base  <= '0;
      end else if (row_end) begin
        col_count <= '0;
        row_count <= row_count + ROW_W'(1);
        row_base  <= row_base + OFFSET_W'(stride);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // Result register: valid bit under reset, payload loaded on acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      write_enable <= we_next;
      byte_offset  <= we_next ? offset_sum : '0;
      pixel_out    <= pixel_in;
      last         <= last_next;
    end
  end

  // A clipped word never carries an offset.
  a_clip_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> byte_offset == '0)
    else $error("clipped word carries a nonzero byte offset");

  // The final pixel of a rectangle restarts all position counters.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_next |=> col_count == '0 && row_count == '0 && row_base == '0)
    else $error("counters did not restart after the last pixel");

  // The result word shows the last mark of the pixel that was accepted.
  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && last == $past(last_next))
    else $error("result word lost its last mark");

  // A free receiver never stalls the source side.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output was free");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present right after reset");

endmodule
